// ----- hdl/ray_box_slab_test_core_assert.svh -----
// Assertion macros for the ray box slab test core.
// Define ASSERT_OFF to drop every check from the build.
`ifndef RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define RBST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RBST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RBST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define RBST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the ray box slab test core.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_CENTER_Z  = 2'd2,
    REG_HALF_SIDE = 2'd3
  } cfg_reg_e;

  // Per-item side info that rides along the pipe
  typedef struct packed {
    logic [AXES-1:0] par;    // direction component is zero
    logic            pmiss;  // parallel axis with start outside the slab
  } side_t;

  // Divider lane control flags
  typedef struct packed {
    logic ovf;  // quotient does not fit the coordinate width
    logic neg;  // quotient is negative
  } div_flags_t;

endpackage

// ----- hdl/rbst_ray_if.sv -----
// ----------------------------------------------------------------------------
// rbst_ray_if
// Ray item channel: origin and direction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbst_ray_if #(parameter int COORD_WIDTH = 32) ();
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] start_x;
  logic [COORD_WIDTH-1:0] start_y;
  logic [COORD_WIDTH-1:0] start_z;
  logic [COORD_WIDTH-1:0] dir_x;
  logic [COORD_WIDTH-1:0] dir_y;
  logic [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

// ----- hdl/rbst_res_if.sv -----
// ----------------------------------------------------------------------------
// rbst_res_if
// Result item channel: hit flag and entry/exit parameters.
// ----------------------------------------------------------------------------
interface rbst_res_if #(parameter int COORD_WIDTH = 32) ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [COORD_WIDTH-1:0] t_near;
  logic [COORD_WIDTH-1:0] t_far;

  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink   (input valid, hit, t_near, t_far, output ready);
endinterface

// ----- hdl/rbst_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rbst_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rbst_cfg_if #(parameter int COORD_WIDTH = 32) ();
  logic                            valid;
  logic                            ready;
  logic [rbst_pkg::CFG_IDX_W-1:0]  index;
  logic [COORD_WIDTH-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/ray_box_slab_test_core.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Slab test of a ray against an axis-aligned cube held in configuration.
// ----------------------------------------------------------------------------
//  channel | role   | moves
//  --------+--------+------------------------------------------------------
//  ray     | sink   | one item: start_x/y/z, dir_x/y/z (signed fixed point)
//  res     | source | one item per ray: hit, t_near, t_far
//  cfg     | sink   | register write: index, data (always ready)
//
//  One item enters per cycle while stage 0 is ready; it runs from stages 0 and
//  1 through the six divider lanes (one quotient bit a stage), F1 and F2.
//  Every stage has its own valid bit and holds only while it is full and the
//  stage after it cannot take its item, so bubbles close up under a stall.
//  Reset (rst, synchronous) clears the valid bits and sets the registers to
//  centre 0 and half side 1.0.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_core_assert.svh"

module ray_box_slab_test_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic       clk,
  input logic       rst,
  rbst_ray_if.sink  ray,
  rbst_res_if.source res,
  rbst_cfg_if.sink  cfg
);

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = CW + 2 + FRAC_BITS;
  localparam int AX    = rbst_pkg::AXES;
  localparam int LN    = rbst_pkg::LANES;
  localparam int ST_F1 = CW + 2;
  localparam int ST_F2 = CW + 3;
  localparam int DEPTH = CW + 5;

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-2:0]        HALF_RST = (CW-1)'(65536);

  // Configuration registers
  logic signed [CW-1:0] center [AX];
  logic [CW-2:0]        half_side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      half_side <= HALF_RST;
    end else if (cfg.valid) begin
      case (rbst_pkg::cfg_reg_e'(cfg.index))
        rbst_pkg::REG_CENTER_X:  center[0] <= cfg.data;
        rbst_pkg::REG_CENTER_Y:  center[1] <= cfg.data;
        rbst_pkg::REG_CENTER_Z:  center[2] <= cfg.data;
        rbst_pkg::REG_HALF_SIDE: half_side <= cfg.data[CW-2:0];
        default: ;
      endcase
    end
  end

  // Stage valids and ready chain
  logic                v   [DEPTH];
  logic                rdy [DEPTH+1];
  rbst_pkg::side_t     side [ST_F2+1];
  rbst_pkg::side_t     side_in;

  assign rdy[DEPTH] = res.ready;
  for (genvar k = 0; k < DEPTH; k++) begin : g_ctl
    assign rdy[k] = !v[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? ray.valid : v[(k == 0) ? 0 : k-1];
      end
    end
  end
  assign ray.ready = rdy[0];
  assign res.valid = v[DEPTH-1];

  // Side info carried along stages 1 .. F2
  for (genvar k = 1; k <= ST_F2; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Stage 0: slab numerators and parallel-axis test
  logic signed [CW-1:0] st [AX];
  logic signed [CW-1:0] dr [AX];
  logic signed [CW+1:0] s0_n [LN];
  logic signed [CW-1:0] s0_d [AX];
  logic signed [CW+1:0] s_e  [AX];
  logic signed [CW+1:0] lo_e [AX];
  logic signed [CW+1:0] hi_e [AX];

  assign st[0] = $signed(ray.start_x);
  assign st[1] = $signed(ray.start_y);
  assign st[2] = $signed(ray.start_z);
  assign dr[0] = $signed(ray.dir_x);
  assign dr[1] = $signed(ray.dir_y);
  assign dr[2] = $signed(ray.dir_z);

  always_comb begin
    side_in = '0;
    for (int a = 0; a < AX; a++) begin
      s_e[a]  = (CW+2)'(st[a]);
      lo_e[a] = (CW+2)'(center[a]) - $signed({3'b000, half_side});
      hi_e[a] = (CW+2)'(center[a]) + $signed({3'b000, half_side});
      side_in.par[a] = (dr[a] == '0);
      if (side_in.par[a] && (s_e[a] < lo_e[a] || s_e[a] > hi_e[a])) begin
        side_in.pmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side[0] <= side_in;
      for (int a = 0; a < AX; a++) begin
        s0_n[2*a]   <= lo_e[a] - s_e[a];
        s0_n[2*a+1] <= hi_e[a] - s_e[a];
        s0_d[a]     <= dr[a];
      end
    end
  end

  // Stage 1: magnitudes, overflow check, first partial remainder
  logic [CW+1:0]        un   [LN];
  logic [CW-1:0]        ud   [LN];
  logic [NW-1:0]        nn   [LN];
  logic [NW-1:0]        nt   [LN];
  logic [CW-1:0]        s1_rem [LN];
  logic [CW-1:0]        s1_low [LN];
  logic [CW-1:0]        s1_den [LN];
  rbst_pkg::div_flags_t s1_flg [LN];

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      un[l] = s0_n[l][CW+1] ? $unsigned(-s0_n[l]) : $unsigned(s0_n[l]);
      ud[l] = s0_d[l/2][CW-1] ? $unsigned(-s0_d[l/2]) : $unsigned(s0_d[l/2]);
      nn[l] = {un[l], {FRAC_BITS{1'b0}}};
      nt[l] = nn[l] >> CW;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < LN; l++) begin
        s1_rem[l]     <= nt[l][CW-1:0];
        s1_low[l]     <= nn[l][CW-1:0];
        s1_den[l]     <= ud[l];
        s1_flg[l].ovf <= (nt[l] >= NW'(ud[l]));
        s1_flg[l].neg <= s0_n[l][CW+1] ^ s0_d[l/2][CW-1];
      end
    end
  end

  // Stages 2 .. CW+1: divider lanes
  logic [CW-1:0]        q_o [LN];
  rbst_pkg::div_flags_t f_o [LN];
  logic [CW-1:0]        div_en;

  for (genvar k = 0; k < CW; k++) begin : g_den
    assign div_en[k] = rdy[k+2];
  end

  for (genvar l = 0; l < LN; l++) begin : g_lane
    rbst_div_lane #(.COORD_WIDTH(CW)) u_lane (
      .clk       (clk),
      .en        (div_en),
      .rem_in    (s1_rem[l]),
      .num_in    (s1_low[l]),
      .den_in    (s1_den[l]),
      .flags_in  (s1_flg[l]),
      .quo_out   (q_o[l]),
      .flags_out (f_o[l])
    );
  end

  // Stage F1: saturate, sign, order each slab
  logic signed [CW-1:0] tv [LN];
  logic signed [CW-1:0] t0 [AX];
  logic signed [CW-1:0] t1 [AX];
  logic signed [CW-1:0] f1_lo [AX];
  logic signed [CW-1:0] f1_hi [AX];
  logic                 sat [LN];

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      sat[l] = f_o[l].ovf ||
               (f_o[l].neg ? (q_o[l][CW-1] && (|q_o[l][CW-2:0])) : q_o[l][CW-1]);
      if (sat[l]) begin
        tv[l] = f_o[l].neg ? T_MIN : T_MAX;
      end else begin
        tv[l] = f_o[l].neg ? $signed(-q_o[l]) : $signed(q_o[l]);
      end
    end
    for (int a = 0; a < AX; a++) begin
      if (side[ST_F1-1].par[a]) begin
        t0[a] = T_MIN;
        t1[a] = T_MAX;
      end else if (tv[2*a] > tv[2*a+1]) begin
        t0[a] = tv[2*a+1];
        t1[a] = tv[2*a];
      end else begin
        t0[a] = tv[2*a];
        t1[a] = tv[2*a+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_F1]) begin
      f1_lo <= t0;
      f1_hi <= t1;
    end
  end

  // Stage F2: intersect the three slab intervals
  logic signed [CW-1:0] nxy, fxy, f2_near, f2_far;

  always_comb begin
    nxy = (f1_lo[0] > f1_lo[1]) ? f1_lo[0] : f1_lo[1];
    fxy = (f1_hi[0] < f1_hi[1]) ? f1_hi[0] : f1_hi[1];
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_F2]) begin
      f2_near <= (nxy > f1_lo[2]) ? nxy : f1_lo[2];
      f2_far  <= (fxy < f1_hi[2]) ? fxy : f1_hi[2];
    end
  end

  // Output register
  logic                 hit_r;
  logic signed [CW-1:0] near_r, far_r;
  logic                 hit_c;

  assign hit_c = !side[ST_F2].pmiss && (f2_near <= f2_far);

  always_ff @(posedge clk) begin
    if (rdy[DEPTH-1]) begin
      hit_r  <= hit_c;
      near_r <= hit_c ? f2_near : '0;
      far_r  <= hit_c ? f2_far  : '0;
    end
  end

  assign res.hit    = hit_r;
  assign res.t_near = near_r;
  assign res.t_far  = far_r;

  // Checks
  `RBST_ASSERT_NOW(a_miss_zero, clk, rst, res.valid && !res.hit, near_r == '0 && far_r == '0, "miss with nonzero parameters")
  `RBST_ASSERT_NOW(a_hit_order, clk, rst, res.valid && res.hit, near_r <= far_r, "hit with t_near above t_far")
  `RBST_ASSERT_NEXT(a_accept_fill, clk, rst, ray.valid && ray.ready, v[0], "accepted item not in first stage")
  `RBST_ASSERT_NOW(a_full_stall, clk, rst, !ray.ready, v[DEPTH-1] && !res.ready, "input stalled without output stall")

endmodule

// ----- hdl/rbst_div_lane.sv -----
// ----------------------------------------------------------------------------
// rbst_div_lane
// Pipelined restoring divider lane, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rbst_div_lane #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic [COORD_WIDTH-1:0]       en,
  input  logic [COORD_WIDTH-1:0]       rem_in,
  input  logic [COORD_WIDTH-1:0]       num_in,
  input  logic [COORD_WIDTH-1:0]       den_in,
  input  rbst_pkg::div_flags_t         flags_in,
  output logic [COORD_WIDTH-1:0]       quo_out,
  output rbst_pkg::div_flags_t         flags_out
);

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0]        rem   [CW];
  logic [CW-1:0]        num   [CW];
  logic [CW-1:0]        den   [CW];
  logic [CW-1:0]        quo   [CW];
  rbst_pkg::div_flags_t flg   [CW];

  logic [CW-1:0]        rem_p [CW];
  logic [CW-1:0]        num_p [CW];
  logic [CW-1:0]        den_p [CW];
  logic [CW-1:0]        quo_p [CW];
  rbst_pkg::div_flags_t flg_p [CW];

  for (genvar i = 0; i < CW; i++) begin : g_step
    logic [CW:0] rs;
    logic [CW:0] diff;
    logic        ge;

    // Stage inputs
    if (i == 0) begin : g_first
      assign rem_p[i] = rem_in;
      assign num_p[i] = num_in;
      assign den_p[i] = den_in;
      assign quo_p[i] = '0;
      assign flg_p[i] = flags_in;
    end else begin : g_next
      assign rem_p[i] = rem[i-1];
      assign num_p[i] = num[i-1];
      assign den_p[i] = den[i-1];
      assign quo_p[i] = quo[i-1];
      assign flg_p[i] = flg[i-1];
    end

    // Shift in one numerator bit, trial subtract
    assign rs   = {rem_p[i], num_p[i][CW-1]};
    assign diff = rs - {1'b0, den_p[i]};
    assign ge   = (rs >= {1'b0, den_p[i]});

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i] <= ge ? diff[CW-1:0] : rs[CW-1:0];
        num[i] <= {num_p[i][CW-2:0], 1'b0};
        den[i] <= den_p[i];
        quo[i] <= {quo_p[i][CW-2:0], ge};
        flg[i] <= flg_p[i];
      end
    end
  end

  assign quo_out   = quo[CW-1];
  assign flags_out = flg[CW-1];

endmodule

// ----- sim/tb_ray_box_slab_test_core.sv -----
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test_core
// Testbench of the ray box slab core: a local slab-test predictor checks
// every result item; directed rays first, then random rays per cube setting.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test_core;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam longint TMAX = 64'sd2147483647;
  localparam longint TMIN = -64'sd2147483648;
  localparam int DRAIN = CW + 20;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] t_near;
    logic [CW-1:0] t_far;
  } slab_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbst_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
  rbst_res_if #(.COORD_WIDTH(CW)) res_ch ();
  rbst_cfg_if #(.COORD_WIDTH(CW)) cfg_ch ();

  ray_box_slab_test_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .ray(ray_ch.sink), .res(res_ch.source), .cfg(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // cube state mirrored for prediction
  logic signed [CW-1:0] cube_ctr [3];
  logic [CW-2:0]        cube_half;

  slab_res_t hits_pending[$];
  int  fail_cnt = 0;
  int  idle_cycles = 0;
  bit  allow_stall = 1'b1;

  // short gaps mostly, sometimes long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // (n * 2^FB) / d truncated toward zero, saturated to CW bits
  function automatic longint slab_quot(longint n, longint d);
    bit neg;
    logic [63:0] un, ud, lim, r, q;
    int i;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    lim = neg ? 64'(TMAX) + 1 : 64'(TMAX);
    r = 0;
    q = 0;
    if (un == 0) return 0;
    for (i = 0; i < 64 + FB; i++) begin
      if (q > (lim >> 1)) return neg ? TMIN : TMAX;
      r = (r << 1) | (i < 64 ? ((un >> (63 - i)) & 1) : 0);
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q[0] = 1'b1;
      end
      if (q > lim) return neg ? TMIN : TMAX;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic slab_res_t slab_predict(logic [CW-1:0] st [3], logic [CW-1:0] dr [3]);
    slab_res_t o;
    longint tn, tf, s, d, lo, hi, t0, t1, tmp;
    bit hit;
    int a;
    tn = TMIN;
    tf = TMAX;
    hit = 1'b1;
    for (a = 0; a < 3; a++) begin
      s = longint'($signed(st[a]));
      d = longint'($signed(dr[a]));
      lo = longint'(cube_ctr[a]) - longint'(cube_half);
      hi = longint'(cube_ctr[a]) + longint'(cube_half);
      if (d == 0) begin
        if (s < lo || s > hi) begin
          hit = 1'b0;
          break;
        end
        continue;
      end
      t0 = slab_quot(lo - s, d);
      t1 = slab_quot(hi - s, d);
      if (t0 > t1) begin
        tmp = t0; t0 = t1; t1 = tmp;
      end
      if (tn > t1 || t0 > tf) begin
        hit = 1'b0;
        break;
      end
      if (t0 > tn) tn = t0;
      if (t1 < tf) tf = t1;
    end
    if (!hit) begin
      tn = 0;
      tf = 0;
    end
    o.hit = hit;
    o.t_near = tn[CW-1:0];
    o.t_far = tf[CW-1:0];
    return o;
  endfunction

  // send one ray and queue its expected result; valid stays high for the
  // next ray unless a gap follows
  task automatic send_ray(logic [CW-1:0] st [3], logic [CW-1:0] dr [3]);
    int g;
    g = 0;
    if (allow_stall) g = gap_len();
    if (g > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    ray_ch.start_x <= st[0]; ray_ch.start_y <= st[1]; ray_ch.start_z <= st[2];
    ray_ch.dir_x <= dr[0]; ray_ch.dir_y <= dr[1]; ray_ch.dir_z <= dr[2];
    ray_ch.valid <= 1'b1;
    do @(posedge clk); while (!ray_ch.ready);
    hits_pending.push_back(slab_predict(st, dr));
    @(negedge clk);
  endtask

  task automatic write_reg(rbst_pkg::cfg_reg_e idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      rbst_pkg::REG_CENTER_X:  cube_ctr[0] = val;
      rbst_pkg::REG_CENTER_Y:  cube_ctr[1] = val;
      rbst_pkg::REG_CENTER_Z:  cube_ctr[2] = val;
      rbst_pkg::REG_HALF_SIDE: cube_half = val[CW-2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and wait until every queued result is back
  task automatic drain_results();
    ray_ch.valid <= 1'b0;
    wait (hits_pending.size() == 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_cube(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                          logic [CW-1:0] h);
    drain_results();
    write_reg(rbst_pkg::REG_CENTER_X, cx);
    write_reg(rbst_pkg::REG_CENTER_Y, cy);
    write_reg(rbst_pkg::REG_CENTER_Z, cz);
    write_reg(rbst_pkg::REG_HALF_SIDE, h);
  endtask

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      3: return 0;
      default: return 32'($signed($urandom_range(0, 80 << FB)) - (40 << FB));
    endcase
  endfunction

  // result checker and cycle watchdog
  always @(posedge clk) begin
    slab_res_t e;
    if (!rst) begin
      if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (hits_pending.size() == 0) begin
          $error("result item with nothing expected");
          fail_cnt++;
        end else begin
          e = hits_pending.pop_front();
          if (res_ch.hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, res_ch.hit);
            fail_cnt++;
          end
          if (res_ch.t_near !== e.t_near) begin
            $error("t_near: expected %h actual %h", e.t_near, res_ch.t_near);
            fail_cnt++;
          end
          if (res_ch.t_far !== e.t_far) begin
            $error("t_far: expected %h actual %h", e.t_far, res_ch.t_far);
            fail_cnt++;
          end
        end
      end
    end
  end

  // result-side backpressure
  initial begin
    int g;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!allow_stall) res_ch.ready <= 1'b1;
      else begin
        g = gap_len();
        if (g == 0) res_ch.ready <= 1'b1;
        else begin
          res_ch.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic test_directed();
    logic [CW-1:0] st [3];
    logic [CW-1:0] dr [3];
    int k;
    // axis rays through default unit cube
    st = '{32'hfffb_0000, 0, 0}; dr = '{32'h0001_0000, 0, 0}; send_ray(st, dr);
    st = '{0, 32'h0005_0000, 0}; dr = '{0, 32'hffff_0000, 0}; send_ray(st, dr);
    // all directions zero, start inside and outside, on the boundary
    st = '{0, 0, 0}; dr = '{0, 0, 0}; send_ray(st, dr);
    st = '{32'h0001_0000, 32'hffff_0000, 32'h0001_0000}; send_ray(st, dr);
    st = '{32'h0001_0001, 0, 0}; send_ray(st, dr);
    // touching edges, grazing diagonal
    st = '{32'hfffe_0000, 32'h0002_0000, 0}; dr = '{32'h0001_0000, 32'hffff_0000, 0};
    send_ray(st, dr);
    // saturation: tiny direction, huge start
    st = '{32'h8000_0000, 0, 0}; dr = '{1, 0, 0}; send_ray(st, dr);
    st = '{32'h7fff_ffff, 0, 0}; dr = '{32'hffff_ffff, 0, 0}; send_ray(st, dr);
    st = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    dr = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}; send_ray(st, dr);
    // miss: disjoint axis intervals
    st = '{32'hfffb_0000, 32'h0003_0000, 0}; dr = '{32'h0001_0000, 32'h0001_0000, 0};
    send_ray(st, dr);
    for (k = 0; k < 6; k++) begin
      st = '{$urandom, $urandom, $urandom}; dr = '{$urandom, $urandom, $urandom};
      send_ray(st, dr);
    end
    // cube at the extremes
    set_cube(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff);
    st = '{0, 0, 0}; dr = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}; send_ray(st, dr);
    st = '{32'h8000_0000, 32'h7fff_ffff, 0}; dr = '{0, 0, 1}; send_ray(st, dr);
    set_cube(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0);
    st = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff}; dr = '{0, 0, 0}; send_ray(st, dr);
    st = '{0, 0, 0}; dr = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff}; send_ray(st, dr);
  endtask

  task automatic test_random();
    logic [CW-1:0] st [3];
    logic [CW-1:0] dr [3];
    int p, k, a;
    for (p = 0; p < 9; p++) begin
      if (p % 3 == 0) set_cube($urandom, $urandom, $urandom, $urandom);
      else set_cube(rnd_coord(), rnd_coord(), rnd_coord(),
                    {1'b0, 31'($urandom_range(0, 20 << FB))});
      // one phase without any stalls
      allow_stall = (p != 4);
      for (k = 0; k < 150; k++) begin
        for (a = 0; a < 3; a++) begin
          st[a] = rnd_coord();
          dr[a] = ($urandom_range(0, 5) == 0) ? 0 : rnd_coord();
          // aim many rays at the cube so hits are common
          if ($urandom_range(0, 1) && dr[a] != 0)
            dr[a] = 32'(($signed(cube_ctr[a]) >>> 4) - ($signed(st[a]) >>> 4));
        end
        send_ray(st, dr);
      end
      allow_stall = 1'b1;
    end
  endtask

  initial begin
    cube_ctr = '{0, 0, 0};
    cube_half = 31'd65536;
    ray_ch.valid = 1'b0;
    ray_ch.start_x = 0; ray_ch.start_y = 0; ray_ch.start_z = 0;
    ray_ch.dir_x = 0; ray_ch.dir_y = 0; ray_ch.dir_z = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = rbst_pkg::REG_CENTER_X;
    cfg_ch.data = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    drain_results();
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rbst_pkg.sv
hdl/rbst_ray_if.sv
hdl/rbst_res_if.sv
hdl/rbst_cfg_if.sv
hdl/rbst_div_lane.sv
hdl/ray_box_slab_test_core.sv
sim/tb_ray_box_slab_test_core.sv
